// ===== src/sacp_pkg.sv =====
// ----------------------------------------------------------------------------
// sacp_pkg
// Shared types and constants for the set-associative cache policy block.
// ----------------------------------------------------------------------------
package sacp_pkg;

  // Default geometry limits
  localparam int MAX_SETS_DEF = 256;
  localparam int MAX_WAYS_DEF = 8;

  // Field widths
  localparam int TAG_W     = 30;
  localparam int STAMP_W   = 32;
  localparam int COST_W    = 18;
  localparam int CNT_W     = 32;
  localparam int TOTAL_W   = 64;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS_USED   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_ALLOC = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_BACK  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LRU_MODE    = 3'd5;

  // Offset range
  localparam logic [3:0] OB_MIN = 4'd2;
  localparam logic [3:0] OB_MAX = 4'd12;

  // Cost constants
  localparam logic [COST_W-1:0] COST_ONE   = 18'd1;
  localparam logic [COST_W-1:0] COST_MEM   = 18'd100;
  localparam logic [COST_W-1:0] COST_DIRTY = 18'd200;

  // Controller to datapath commands
  typedef struct packed {
    logic clear;
    logic accept;
    logic read;
    logic lookup;
    logic update;
  } sacp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clear_done;
    logic out_full;
  } sacp_status_t;

endpackage

// ===== src/sacp_ctrl.sv =====
// ----------------------------------------------------------------------------
// sacp_ctrl
// Sequencer: clearing pass, accept, row read, lookup, update.
// ----------------------------------------------------------------------------
module sacp_ctrl
  import sacp_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  input  logic         out_ready,
  input  sacp_status_t status,
  output sacp_cmd_t    cmd,
  output logic         in_ready
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_LOOK  = 3'd3;
  localparam logic [2:0] ST_UPD   = 3'd4;

  logic [2:0] state_r, state_nxt;

  // Command decode
  always_comb begin
    cmd        = '0;
    cmd.clear  = (state_r == ST_CLEAR) && !status.clear_done;
    cmd.accept = (state_r == ST_IDLE) && in_valid;
    cmd.read   = (state_r == ST_READ);
    cmd.lookup = (state_r == ST_LOOK);
    cmd.update = (state_r == ST_UPD) && (!status.out_full || out_ready);
  end

  assign in_ready = (state_r == ST_IDLE);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (status.clear_done) state_nxt = ST_IDLE;
      ST_IDLE:  if (cmd.accept) state_nxt = ST_READ;
      ST_READ:  state_nxt = ST_LOOK;
      ST_LOOK:  state_nxt = ST_UPD;
      ST_UPD:   if (cmd.update) state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_CLEAR;
    else        state_r <= state_nxt;
  end

endmodule

// ===== src/sacp_dpath.sv =====
// ----------------------------------------------------------------------------
// sacp_dpath
// Config registers, line memories, hit/victim search, counters, output reg.
// ----------------------------------------------------------------------------
module sacp_dpath
  import sacp_pkg::*;
#(
  parameter int MAX_SETS = MAX_SETS_DEF,
  parameter int MAX_WAYS = MAX_WAYS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sacp_cmd_t            cmd,
  output sacp_status_t         status,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_func,
  input  logic [31:0]          in_address,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic                 out_hit,
  output logic                 out_dirty_evict,
  output logic [COST_W-1:0]    out_cycles_added,
  output logic [TOTAL_W-1:0]   out_total_cycles,
  output logic [CNT_W-1:0]     out_load_hit_count,
  output logic [CNT_W-1:0]     out_load_miss_count,
  output logic [CNT_W-1:0]     out_store_hit_count,
  output logic [CNT_W-1:0]     out_store_miss_count
);

  localparam int IW     = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int CW     = $clog2(MAX_SETS + 1);
  localparam int SB_MAX = $clog2(MAX_SETS + 1) - 1;
  localparam int LW     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int P      = 1 << LW;
  localparam int NWW    = $clog2(MAX_WAYS + 1);
  localparam int KEY_W  = STAMP_W + 2;

  // Configuration registers
  logic [3:0] set_bits_r, offset_bits_r, ways_used_r;
  logic       write_alloc_r, write_back_r, lru_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_bits_r    <= 4'd0;
      offset_bits_r <= 4'd4;
      ways_used_r   <= 4'd1;
      write_alloc_r <= 1'b1;
      write_back_r  <= 1'b1;
      lru_mode_r    <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SET_BITS:    set_bits_r    <= cfg_wdata;
        CFG_OFFSET_BITS: offset_bits_r <= cfg_wdata;
        CFG_WAYS_USED:   ways_used_r   <= cfg_wdata;
        CFG_WRITE_ALLOC: write_alloc_r <= cfg_wdata[0];
        CFG_WRITE_BACK:  write_back_r  <= cfg_wdata[0];
        CFG_LRU_MODE:    lru_mode_r    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Effective geometry
  logic [3:0]     ob_eff, sb_eff;
  logic [NWW-1:0] nw_eff;
  logic [31:0]    set_full, tag_full;

  always_comb begin
    if (offset_bits_r < OB_MIN)      ob_eff = OB_MIN;
    else if (offset_bits_r > OB_MAX) ob_eff = OB_MAX;
    else                             ob_eff = offset_bits_r;
    if (set_bits_r > 4'(SB_MAX)) sb_eff = 4'(SB_MAX);
    else                         sb_eff = set_bits_r;
    if (ways_used_r == 4'd0)                     nw_eff = NWW'(1);
    else if ({1'b0, ways_used_r} > 5'(MAX_WAYS)) nw_eff = NWW'(MAX_WAYS);
    else                                         nw_eff = NWW'(ways_used_r);
    set_full = (in_address >> ob_eff) & ((32'd1 << sb_eff) - 32'd1);
    tag_full = in_address >> ({1'b0, ob_eff} + {1'b0, sb_eff});
  end

  // Request registers
  logic             req_store_r;
  logic [IW-1:0]    req_set_r;
  logic [TAG_W-1:0] req_tag_r;
  logic [3:0]       req_ob_r;
  logic [NWW-1:0]   req_nw_r;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_store_r <= in_func;
      req_set_r   <= set_full[IW-1:0];
      req_tag_r   <= tag_full[TAG_W-1:0];
      req_ob_r    <= ob_eff;
      req_nw_r    <= nw_eff;
    end
  end

  // Line memories, one row per set
  logic [MAX_WAYS-1:0]              valid_mem [MAX_SETS];
  logic [MAX_WAYS-1:0]              dirty_mem [MAX_SETS];
  logic [MAX_WAYS-1:0][TAG_W-1:0]   tag_mem   [MAX_SETS];
  logic [MAX_WAYS-1:0][STAMP_W-1:0] stamp_mem [MAX_SETS];

  logic [MAX_WAYS-1:0]              rd_valid_r, rd_dirty_r;
  logic [MAX_WAYS-1:0][TAG_W-1:0]   rd_tag_r;
  logic [MAX_WAYS-1:0][STAMP_W-1:0] rd_stamp_r;

  logic [MAX_WAYS-1:0]              wr_valid, wr_dirty;
  logic [MAX_WAYS-1:0][TAG_W-1:0]   wr_tag;
  logic [MAX_WAYS-1:0][STAMP_W-1:0] wr_stamp;
  logic [IW-1:0]                    wr_addr;
  logic                             wr_en;

  // Clearing pass counter
  logic [CW-1:0] clr_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n)         clr_idx_r <= '0;
    else if (cmd.clear) clr_idx_r <= clr_idx_r + CW'(1);
  end

  assign status.clear_done = (clr_idx_r == CW'(MAX_SETS));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      valid_mem[wr_addr] <= wr_valid;
      dirty_mem[wr_addr] <= wr_dirty;
      tag_mem[wr_addr]   <= wr_tag;
      stamp_mem[wr_addr] <= wr_stamp;
    end
    if (cmd.read) begin
      rd_valid_r <= valid_mem[req_set_r];
      rd_dirty_r <= dirty_mem[req_set_r];
      rd_tag_r   <= tag_mem[req_set_r];
      rd_stamp_r <= stamp_mem[req_set_r];
    end
  end

  // Lookup: hit search and oldest-way tree
  logic [MAX_WAYS-1:0] match;
  logic [LW-1:0]       hit_way, vic_way;
  logic [KEY_W-1:0]    key_n [2*P];
  logic [LW-1:0]       idx_n [2*P];

  always_comb begin
    hit_way = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      match[w] = rd_valid_r[w] && (rd_tag_r[w] == req_tag_r) && (NWW'(w) < req_nw_r);
    end
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (match[w]) hit_way = LW'(w);
    end
    // leaves: out-of-range ways rank last, invalid ways first
    for (int w = 0; w < P; w++) begin
      idx_n[P+w] = LW'(w);
      if (w >= MAX_WAYS)              key_n[P+w] = {1'b1, 1'b1, {STAMP_W{1'b1}}};
      else if (NWW'(w) >= req_nw_r)   key_n[P+w] = {1'b1, 1'b1, {STAMP_W{1'b1}}};
      else if (!rd_valid_r[w])        key_n[P+w] = '0;
      else                            key_n[P+w] = {1'b0, 1'b1, rd_stamp_r[w]};
    end
    key_n[0] = '0;
    idx_n[0] = '0;
    // ties keep the left, lower-numbered way
    for (int i = P - 1; i >= 1; i--) begin
      if (key_n[2*i+1] < key_n[2*i]) begin
        key_n[i] = key_n[2*i+1];
        idx_n[i] = idx_n[2*i+1];
      end else begin
        key_n[i] = key_n[2*i];
        idx_n[i] = idx_n[2*i];
      end
    end
    vic_way = idx_n[1];
  end

  logic          hit_r, vdirty_r;
  logic [LW-1:0] way_r;

  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      hit_r    <= |match;
      way_r    <= (|match) ? hit_way : vic_way;
      vdirty_r <= rd_valid_r[vic_way] && rd_dirty_r[vic_way];
    end
  end

  // Update: row rewrite, cost and counters
  logic [STAMP_W-1:0] clock_r, clock_nxt;
  logic [COST_W-1:0]  cost;
  logic               alloc, devict;
  logic [1:0]         bump_k;

  always_comb begin
    clock_nxt = clock_r + STAMP_W'(1);
    alloc     = !hit_r && !(req_store_r && !write_alloc_r);
    devict    = alloc && vdirty_r;
    wr_valid  = rd_valid_r;
    wr_dirty  = rd_dirty_r;
    wr_tag    = rd_tag_r;
    wr_stamp  = rd_stamp_r;
    bump_k    = {req_store_r, !hit_r};
    if (hit_r) begin
      if (lru_mode_r) wr_stamp[way_r] = clock_nxt;
      if (req_store_r && write_back_r) wr_dirty[way_r] = 1'b1;
      cost = (req_store_r && !write_back_r) ? COST_MEM : COST_ONE;
    end else if (!alloc) begin
      cost = COST_MEM;
    end else begin
      wr_valid[way_r] = 1'b1;
      wr_tag[way_r]   = req_tag_r;
      wr_stamp[way_r] = clock_nxt;
      wr_dirty[way_r] = req_store_r && write_back_r;
      cost = ((vdirty_r ? COST_DIRTY : COST_MEM) << (req_ob_r - OB_MIN)) + COST_ONE;
    end
    // clearing pass overrides
    wr_en   = cmd.clear || cmd.update;
    wr_addr = req_set_r;
    if (cmd.clear) begin
      wr_addr  = clr_idx_r[IW-1:0];
      wr_valid = '0;
      wr_dirty = '0;
      wr_tag   = '0;
      wr_stamp = '0;
    end
  end

  logic [CNT_W-1:0]   cnt_r [4];
  logic [TOTAL_W-1:0] total_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_r <= '0;
      total_r <= '0;
      for (int k = 0; k < 4; k++) cnt_r[k] <= '0;
    end else if (cmd.update) begin
      clock_r <= clock_nxt;
      total_r <= total_r + TOTAL_W'(cost);
      if (cnt_r[bump_k] != {CNT_W{1'b1}}) cnt_r[bump_k] <= cnt_r[bump_k] + CNT_W'(1);
    end
  end

  // Output register
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n)                     out_valid_r <= 1'b0;
    else if (cmd.update)            out_valid_r <= 1'b1;
    else if (out_ready)             out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      out_hit          <= hit_r;
      out_dirty_evict  <= devict;
      out_cycles_added <= cost;
    end
  end

  assign status.out_full      = out_valid_r;
  assign out_valid            = out_valid_r;
  assign out_total_cycles     = total_r;
  assign out_load_hit_count   = cnt_r[0];
  assign out_load_miss_count  = cnt_r[1];
  assign out_store_hit_count  = cnt_r[2];
  assign out_store_miss_count = cnt_r[3];

endmodule

// ===== src/set_assoc_cache_policy.sv =====
// ----------------------------------------------------------------------------
// set_assoc_cache_policy
// Flow: an access is accepted, then the row is read, the lookup is registered,
// and the row update loads the output register; no new access is accepted
// until that update, which is held while a finished result waits on out_ready.
// Reset: synchronous; a clearing pass zeroes every set of the line memories,
// and in_ready stays low until it ends.
// Config writes take effect at once; issue them only with no access in flight.
// ----------------------------------------------------------------------------
module set_assoc_cache_policy
  import sacp_pkg::*;
#(
  parameter int MAX_SETS = MAX_SETS_DEF,
  parameter int MAX_WAYS = MAX_WAYS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_func,
  input  logic [31:0]          in_address,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_hit,
  output logic                 out_dirty_evict,
  output logic [COST_W-1:0]    out_cycles_added,
  output logic [TOTAL_W-1:0]   out_total_cycles,
  output logic [CNT_W-1:0]     out_load_hit_count,
  output logic [CNT_W-1:0]     out_load_miss_count,
  output logic [CNT_W-1:0]     out_store_hit_count,
  output logic [CNT_W-1:0]     out_store_miss_count
);

  sacp_cmd_t    cmd;
  sacp_status_t status;

  sacp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd),
    .in_ready  (in_ready)
  );

  sacp_dpath #(
    .MAX_SETS (MAX_SETS),
    .MAX_WAYS (MAX_WAYS)
  ) u_dpath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .status               (status),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_func              (in_func),
    .in_address           (in_address),
    .out_ready            (out_ready),
    .out_valid            (out_valid),
    .out_hit              (out_hit),
    .out_dirty_evict      (out_dirty_evict),
    .out_cycles_added     (out_cycles_added),
    .out_total_cycles     (out_total_cycles),
    .out_load_hit_count   (out_load_hit_count),
    .out_load_miss_count  (out_load_miss_count),
    .out_store_hit_count  (out_store_hit_count),
    .out_store_miss_count (out_store_miss_count)
  );

  // No transaction accepted before the clearing pass is done
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !status.clear_done |-> !in_ready)
    else $error("input accepted during clearing pass");

  // One access in flight at a time
  a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second access accepted while busy");

  // An update always lands in the output register
  a_update_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.update |=> out_valid)
    else $error("update did not produce a result");

  // Clearing never overlaps an update or an accept
  a_clear_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.clear && (cmd.update || cmd.accept)))
    else $error("memory clear overlaps an access");

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the set-associative cache policy block. Load and
// store addresses go in over a valid/ready channel. A behavioral copy of the
// tag, dirty and timestamp arrays predicts hit, dirty eviction, cost and the
// running totals of each access. Every result is compared field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import sacp_pkg::*;

  localparam int SETS      = MAX_SETS_DEF;
  localparam int WAYS      = MAX_WAYS_DEF;
  localparam int LINES     = SETS * WAYS;
  localparam int STALL_MAX = 5000;
  localparam int LATENCY   = 12;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_STORE = 1'b1;

  typedef struct packed {
    logic               hit;
    logic               dirty_evict;
    logic [COST_W-1:0]  cycles_added;
    logic [TOTAL_W-1:0] total_cycles;
    logic [CNT_W-1:0]   load_hits;
    logic [CNT_W-1:0]   load_misses;
    logic [CNT_W-1:0]   store_hits;
    logic [CNT_W-1:0]   store_misses;
  } access_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_func = 1'b0;
  logic [31:0]          in_address = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 out_hit;
  logic                 out_dirty_evict;
  logic [COST_W-1:0]    out_cycles_added;
  logic [TOTAL_W-1:0]   out_total_cycles;
  logic [CNT_W-1:0]     out_load_hit_count;
  logic [CNT_W-1:0]     out_load_miss_count;
  logic [CNT_W-1:0]     out_store_hit_count;
  logic [CNT_W-1:0]     out_store_miss_count;

  set_assoc_cache_policy dut (.*);

  // Mirror of the cache state
  logic               line_ok    [LINES];
  logic [TAG_W-1:0]   line_tag_m [LINES];
  logic               line_dirty_m [LINES];
  logic [STAMP_W-1:0] line_stamp_m [LINES];
  logic [STAMP_W-1:0] access_tick;
  logic [TOTAL_W-1:0] cost_sum;
  logic [CNT_W-1:0]   load_hits, load_misses, store_hits, store_misses;
  logic [3:0]         geo_sets, geo_offset, geo_ways;
  logic               alloc_on_store, write_back_on, lru_on;

  access_result_t pending_results[$];
  int   error_count = 0;
  int   sender_idle_pct = 0;
  int   receiver_stall_pct = 0;
  bit   hold_receiver = 0;
  int   quiet_cycles = 0;
  logic [TAG_W-1:0] tag_pool[$];

  // Clock
  initial begin
    forever #4 clk = ~clk;
  end

  // Effective geometry after clamping
  function automatic int eff_offset();
    return (geo_offset < OB_MIN) ? OB_MIN : ((geo_offset > OB_MAX) ? OB_MAX : geo_offset);
  endfunction

  function automatic int eff_sets();
    return (geo_sets > 8) ? 8 : geo_sets;
  endfunction

  function automatic int eff_ways();
    return (geo_ways == 0) ? 1 : ((geo_ways > WAYS) ? WAYS : geo_ways);
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + 1;
  endfunction

  // Compute the result of one access and update the mirror
  function automatic access_result_t predict_access(logic func, logic [31:0] addr);
    access_result_t r;
    int ob, sb, nw, set_idx, base, hit_line, victim;
    logic [TAG_W-1:0] tg;
    logic [COST_W-1:0] cost;
    bit hit, have_free, vd;
    ob = eff_offset();
    sb = eff_sets();
    nw = eff_ways();
    set_idx = (addr >> ob) & ((1 << sb) - 1);
    tg = TAG_W'(addr >> (ob + sb));
    base = set_idx * WAYS;
    hit = 0;
    hit_line = 0;
    have_free = 0;
    victim = base;
    vd = 0;
    access_tick = access_tick + 1;
    for (int w = 0; w < nw; w++) begin
      if (!hit && line_ok[base+w] && line_tag_m[base+w] == tg) begin
        hit = 1;
        hit_line = base + w;
      end
    end
    // victim: first free way, else oldest stamp, lowest way on ties
    if (!hit) begin
      for (int w = 0; w < nw; w++) begin
        if (!line_ok[base+w]) begin
          if (!have_free) begin
            have_free = 1;
            victim = base + w;
          end
        end else if (!have_free && (w == 0 || line_stamp_m[base+w] < line_stamp_m[victim])) begin
          victim = base + w;
        end
      end
    end
    if (hit) begin
      if (lru_on) line_stamp_m[hit_line] = access_tick;
      if (func == FUNC_LOAD) begin
        load_hits = sat_inc(load_hits);
        cost = COST_ONE;
      end else begin
        store_hits = sat_inc(store_hits);
        if (write_back_on) begin
          line_dirty_m[hit_line] = 1'b1;
          cost = COST_ONE;
        end else begin
          cost = COST_MEM;
        end
      end
    end else if (func == FUNC_STORE && !alloc_on_store) begin
      store_misses = sat_inc(store_misses);
      cost = COST_MEM;
    end else begin
      vd = line_ok[victim] && line_dirty_m[victim];
      if (func == FUNC_STORE) store_misses = sat_inc(store_misses);
      else load_misses = sat_inc(load_misses);
      cost = COST_W'((1 << (ob - 2)) * (vd ? COST_DIRTY : COST_MEM) + 1);
      line_ok[victim] = 1'b1;
      line_tag_m[victim] = tg;
      line_stamp_m[victim] = access_tick;
      line_dirty_m[victim] = (func == FUNC_STORE) && write_back_on;
    end
    cost_sum = cost_sum + cost;
    r.hit = hit;
    r.dirty_evict = vd;
    r.cycles_added = cost;
    r.total_cycles = cost_sum;
    r.load_hits = load_hits;
    r.load_misses = load_misses;
    r.store_hits = store_hits;
    r.store_misses = store_misses;
    return r;
  endfunction

  // Register write, mirrored into the predictor
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_SET_BITS:    geo_sets = val;
      CFG_OFFSET_BITS: geo_offset = val;
      CFG_WAYS_USED:   geo_ways = val;
      CFG_WRITE_ALLOC: alloc_on_store = val[0];
      CFG_WRITE_BACK:  write_back_on = val[0];
      CFG_LRU_MODE:    lru_on = val[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_config(logic [3:0] sb, logic [3:0] ob, logic [3:0] nw,
                            logic wa, logic wb, logic lru);
    cfg_write(CFG_SET_BITS, sb);
    cfg_write(CFG_OFFSET_BITS, ob);
    cfg_write(CFG_WAYS_USED, nw);
    cfg_write(CFG_WRITE_ALLOC, {3'b0, wa});
    cfg_write(CFG_WRITE_BACK, {3'b0, wb});
    cfg_write(CFG_LRU_MODE, {3'b0, lru});
  endtask

  // Send one access; valid is left high so back-to-back items need no toggle
  task automatic send_access(logic func, logic [31:0] addr);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < sender_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= func;
    in_address <= addr;
    do @(posedge clk); while (!in_ready);
    pending_results.insert(pending_results.size(), predict_access(func, addr));
  endtask

  // Drop valid, wait for all results, then let the pipeline settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  // Address that mostly lands in sets 0 to 3 with tags from a small pool
  function automatic logic [31:0] pick_address();
    int ob, sb;
    logic [31:0] a;
    ob = eff_offset();
    sb = eff_sets();
    if ($urandom_range(99) < 15) return $urandom;
    a = 32'(tag_pool[$urandom_range(tag_pool.size() - 1)]) << (ob + sb);
    a = a | (32'($urandom_range(3)) << ob);
    a = a | ($urandom & ((32'd1 << ob) - 1));
    return a;
  endfunction

  task automatic fill_tag_pool();
    int n;
    n = $urandom_range(1, 2 * eff_ways() + 2);
    tag_pool.delete();
    for (int i = 0; i < n; i++) tag_pool.insert(tag_pool.size(), TAG_W'($urandom_range(15)));
    if ($urandom_range(1)) tag_pool.insert(tag_pool.size(), TAG_W'($urandom));
  endtask

  task automatic random_phase(int count, int idle_pct, int stall_pct);
    sender_idle_pct = idle_pct;
    receiver_stall_pct = stall_pct;
    fill_tag_pool();
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 49) fill_tag_pool();
      send_access(logic'($urandom_range(1)), pick_address());
    end
    drain();
  endtask

  // Extremes of address, both access kinds, clamped geometry
  task automatic test_directed();
    send_access(FUNC_LOAD, 32'h0000_0000);
    send_access(FUNC_STORE, 32'h0000_0004);
    send_access(FUNC_LOAD, 32'hFFFF_FFFF);
    send_access(FUNC_STORE, 32'hFFFF_FFF0);
    send_access(FUNC_LOAD, 32'h0000_0008);
    drain();
    // clamped: set_bits above limit, offset below minimum, ways zero
    set_config(4'd15, 4'd0, 4'd0, 1'b0, 1'b0, 1'b0);
    send_access(FUNC_STORE, 32'h1234_5678);
    send_access(FUNC_LOAD, 32'h1234_5678);
    send_access(FUNC_STORE, 32'h1234_5678);
    send_access(FUNC_LOAD, 32'hAAAA_AAAA);
    drain();
    // large blocks, max ways, write-back dirty evictions
    set_config(4'd0, 4'd15, 4'd15, 1'b1, 1'b1, 1'b1);
    for (int i = 0; i < 9; i++) send_access(FUNC_STORE, 32'(i) << 12);
    send_access(FUNC_LOAD, 32'h0000_0000);
    send_access(FUNC_LOAD, 32'h5555_5555);
    drain();
    // lines kept across a geometry change
    set_config(4'd8, 4'd12, 4'd8, 1'b1, 1'b1, 1'b1);
    send_access(FUNC_LOAD, 32'h0000_1000);
    send_access(FUNC_STORE, 32'hFFFF_FFFF);
    drain();
  endtask

  // LRU versus FIFO replacement with each write policy
  task automatic test_policies();
    set_config(4'd1, 4'd4, 4'd2, 1'b1, 1'b1, 1'b1);
    random_phase(150, 0, 0);
    set_config(4'd2, 4'd2, 4'd4, 1'b0, 1'b0, 1'b0);
    random_phase(150, 76, 0);
    set_config(4'd0, 4'd3, 4'd3, 1'b1, 1'b0, 1'b0);
    random_phase(150, 0, 76);
    set_config(4'd3, 4'd5, 4'd8, 1'b0, 1'b1, 1'b1);
    random_phase(150, 18, 18);
  endtask

  // Random geometry and policy per phase
  task automatic test_random_configs();
    int idle_tbl[4] = '{0, 76, 0, 18};
    int stall_tbl[4] = '{0, 0, 76, 18};
    for (int p = 0; p < 4; p++) begin
      set_config(4'($urandom_range(15)), 4'($urandom_range(2, 8)), 4'($urandom_range(15)),
                 logic'($urandom_range(1)), logic'($urandom_range(1)),
                 logic'($urandom_range(1)));
      random_phase(140, idle_tbl[p], stall_tbl[p]);
    end
  endtask

  // Receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    set_config(4'd2, 4'd4, 4'd2, 1'b1, 1'b1, 1'b1);
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    fill_tag_pool();
    fork
      begin
        hold_receiver = 1;
        repeat (300) @(posedge clk);
        hold_receiver = 0;
      end
      begin
        for (int i = 0; i < 80; i++) send_access(logic'($urandom_range(1)), pick_address());
      end
    join
    drain();
  endtask

  // Receiver ready pattern
  always @(posedge clk) begin
    out_ready <= !hold_receiver && ($urandom_range(99) >= receiver_stall_pct);
  end

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
      error_count++;
    end
  endtask

  // Result checker
  always @(posedge clk) begin
    access_result_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result transaction", $time);
        error_count++;
      end else begin
        exp_r = pending_results.pop_front();
        check_field("hit", exp_r.hit, out_hit);
        check_field("dirty_evict", exp_r.dirty_evict, out_dirty_evict);
        check_field("cycles_added", exp_r.cycles_added, out_cycles_added);
        check_field("total_cycles", exp_r.total_cycles, out_total_cycles);
        check_field("load_hit_count", exp_r.load_hits, out_load_hit_count);
        check_field("load_miss_count", exp_r.load_misses, out_load_miss_count);
        check_field("store_hit_count", exp_r.store_hits, out_store_hit_count);
        check_field("store_miss_count", exp_r.store_misses, out_store_miss_count);
      end
    end
  end

  // Watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_MAX) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < LINES; i++) begin
      line_ok[i] = 1'b0;
      line_dirty_m[i] = 1'b0;
      line_stamp_m[i] = '0;
      line_tag_m[i] = '0;
    end
    access_tick = '0;
    cost_sum = '0;
    load_hits = '0;
    load_misses = '0;
    store_hits = '0;
    store_misses = '0;
    geo_sets = 4'd0;
    geo_offset = 4'd4;
    geo_ways = 4'd1;
    alloc_on_store = 1'b1;
    write_back_on = 1'b1;
    lru_on = 1'b1;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_policies();
    test_random_configs();
    test_backpressure();
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/sacp_pkg.sv
src/sacp_ctrl.sv
src/sacp_dpath.sv
src/set_assoc_cache_policy.sv
bench/tb_top.sv
